// ===== src/tmep_pkg.sv =====
// Shared types and constants of the terminal mouse escape parser.
`timescale 1ns / 1ps

package tmep_pkg;

  localparam int BUTTON_BITS_DEFAULT = 16;
  localparam int COORD_BITS_DEFAULT  = 16;
  localparam int MASK_W              = 16;
  localparam int TIME_W              = 32;
  localparam int WINDOW_W            = 16;
  localparam int CFG_ADDR_W          = 3;
  localparam int CFG_DATA_W          = 32;

  localparam logic [7:0] CH_ESC          = 8'h1b;
  localparam logic [7:0] CH_LBRACKET     = 8'h5b;
  localparam logic [7:0] CH_X10          = 8'h4d;
  localparam logic [7:0] CH_SGR          = 8'h3c;
  localparam logic [7:0] CH_SEMI         = 8'h3b;
  localparam logic [7:0] CH_RELEASE      = 8'h6d;
  localparam logic [7:0] CH_ZERO         = 8'h30;
  localparam logic [7:0] CH_NINE         = 8'h39;
  localparam logic [7:0] X10_CTRL_OFFSET = 8'h20;
  localparam logic [7:0] X10_POS_OFFSET  = 8'h21;

  localparam logic [7:0] WHEEL_MASK  = 8'h7c;
  localparam logic [7:0] WHEEL_CLEAR = 8'h78;
  localparam logic [1:0] MAX_CLICKS  = 2'd3;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd400;
  localparam logic                REG_WINDOW   = 1'b0;

  typedef enum logic [2:0] {
    PH_GROUND = 3'd0,
    PH_ESCAPE = 3'd1,
    PH_CSI    = 3'd2,
    PH_X10    = 3'd3,
    PH_SGR    = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    EV_KEYDOWN = 3'd0,
    EV_DOWN    = 3'd1,
    EV_UP      = 3'd2,
    EV_CLICK   = 3'd3,
    EV_MOVE    = 3'd4
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic [1:0] clicks;
    logic       record_press;
  } mouse_res_t;

endpackage

// ===== src/tmep_byte_if.sv =====
// Byte channel: one terminal byte and its arrival time per beat.
`timescale 1ns / 1ps

interface tmep_byte_if;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  in_byte;
  logic [tmep_pkg::TIME_W-1:0] arrival_ms;

  modport source (output valid, output in_byte, output arrival_ms, input ready);
  modport sink (input valid, input in_byte, input arrival_ms, output ready);
endinterface

// ===== src/tmep_event_if.sv =====
// Event channel: one key or mouse event per beat.
`timescale 1ns / 1ps

interface tmep_event_if #(
  parameter int COORD_BITS = tmep_pkg::COORD_BITS_DEFAULT
);
  logic                        valid;
  logic                        ready;
  tmep_pkg::ev_kind_t          event_kind;
  logic [7:0]                  key_code;
  logic signed [COORD_BITS:0]  pos_x;
  logic signed [COORD_BITS:0]  pos_y;
  logic [tmep_pkg::MASK_W-1:0] button_mask;
  logic [1:0]                  click_count;
  logic [tmep_pkg::TIME_W-1:0] event_ms;

  modport source (output valid, output event_kind, output key_code, output pos_x,
                  output pos_y, output button_mask, output click_count,
                  output event_ms, input ready);
  modport sink (input valid, input event_kind, input key_code, input pos_x,
                input pos_y, input button_mask, input click_count,
                input event_ms, output ready);
endinterface

// ===== src/tmep_mouse.sv =====
// Button mask update and repeated-click detection for one mouse report.
`timescale 1ns / 1ps

module tmep_mouse #(
  parameter int BUTTON_BITS = tmep_pkg::BUTTON_BITS_DEFAULT,
  parameter int COORD_BITS  = tmep_pkg::COORD_BITS_DEFAULT
) (
  input  logic [COORD_BITS-1:0]         ctrl,
  input  logic                          is_x10,
  input  logic                          is_release,
  input  logic [BUTTON_BITS-1:0]        held,
  input  logic [BUTTON_BITS-1:0]        last_buttons,
  input  logic [1:0]                    last_clicks,
  input  logic [tmep_pkg::TIME_W-1:0]   last_ms,
  input  logic [tmep_pkg::TIME_W-1:0]   now_ms,
  input  logic [tmep_pkg::WINDOW_W-1:0] window_ms,
  output logic [BUTTON_BITS-1:0]        held_next,
  output tmep_pkg::mouse_res_t          res
);
  import tmep_pkg::*;

  localparam int EXT_W = COORD_BITS - 6;
  localparam int BTN_W = COORD_BITS - 4;

  logic [EXT_W-1:0]       ext;
  logic [1:0]             low_btn;
  logic [BTN_W-1:0]       btn;
  logic                   btn_in_range;
  logic [BUTTON_BITS-1:0] btn_bit;
  logic [BUTTON_BITS-1:0] base;
  logic [TIME_W-1:0]      gap;
  logic                   repeat_hit;
  ev_kind_t               kind;

  assign ext     = ctrl[COORD_BITS-1:6];
  assign low_btn = ctrl[1:0];
  // extension buttons: 4*ext + low - 1
  assign btn = (ext != '0) ? ({ext, low_btn} - BTN_W'(1)) : BTN_W'(low_btn);
  assign btn_in_range = (32'(btn) < 32'(BUTTON_BITS));
  assign btn_bit = btn_in_range ? (BUTTON_BITS'(1) << btn) : '0;
  assign base    = held & ~BUTTON_BITS'(WHEEL_CLEAR);
  assign gap     = now_ms - last_ms;

  always_comb begin
    held_next = held;
    kind      = EV_MOVE;
    if (!ctrl[5]) begin
      if (ext == '0 && low_btn == 2'd3 && is_x10) begin
        held_next = '0;
        kind      = EV_UP;
      end else if (is_release) begin
        held_next = base & ~btn_bit;
        kind      = EV_UP;
      end else begin
        held_next = base | btn_bit;
        kind      = ((held_next & BUTTON_BITS'(WHEEL_MASK)) != '0) ? EV_CLICK : EV_DOWN;
      end
    end
  end

  assign repeat_hit = (gap <= TIME_W'(window_ms)) && (last_buttons == held_next) &&
                      (last_clicks != MAX_CLICKS);

  always_comb begin
    res.kind         = kind;
    res.clicks       = 2'd0;
    res.record_press = 1'b0;
    if (kind == EV_DOWN) begin
      res.record_press = 1'b1;
      if (repeat_hit) begin
        res.kind   = EV_CLICK;
        res.clicks = last_clicks + 2'd1;
      end
    end else if (kind == EV_CLICK) begin
      res.clicks = 2'd1;
    end
  end

endmodule

// ===== src/terminal_mouse_escape_parser_unit.sv =====
// Top level of the terminal mouse escape parser.
`timescale 1ns / 1ps

// Terminal byte parser for key events and xterm X10 / SGR mouse reports.
// byte_stream carries one byte with its arrival time per beat; event_stream
// carries at most one key or mouse event for each byte. A byte is held in an
// input register, parsed in the next cycle by a single pass of logic, and
// its event lands in the output register. Throughput is one byte per cycle
// while event_stream does not stall, set by the parse step, which reads the
// state left by the byte before it.
// When event_stream stalls with an event waiting, the input register holds
// its byte; byte_stream.ready follows event_stream.ready in that case, so a
// new byte is still taken in the cycle the waiting event leaves.
// The APB port holds the double-click window at byte addresses 0 to 3
// (reset 400 ms); other writes are dropped. Reset (rst, synchronous) returns
// the parser to ground, releases all buttons, clears click history and
// empties both registers; no clearing pass is needed.
module terminal_mouse_escape_parser_unit #(
  parameter int BUTTON_BITS = tmep_pkg::BUTTON_BITS_DEFAULT,
  parameter int COORD_BITS  = tmep_pkg::COORD_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tmep_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tmep_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tmep_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  tmep_byte_if.sink                       byte_stream,
  tmep_event_if.source                    event_stream
);
  import tmep_pkg::*;

  localparam int POS_W = COORD_BITS + 1;

  // configuration
  logic [WINDOW_W-1:0] window_ms;
  logic                cfg_index;

  // input register
  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic [TIME_W-1:0] s1_ms;
  logic              s1_fire;

  // parser state
  phase_t                 phase, phase_next;
  logic [1:0]             x10_count, x10_count_next;
  logic [7:0]             x10_bytes [2];
  logic [COORD_BITS-1:0]  sgr_values [3];
  logic [1:0]             sgr_field_index, sgr_field_index_next;
  logic                   sgr_stopped, sgr_stopped_next;
  logic                   sgr_digit_seen, sgr_digit_seen_next;
  logic [BUTTON_BITS-1:0] held_buttons;
  logic [TIME_W-1:0]      last_press_ms;
  logic [BUTTON_BITS-1:0] last_press_buttons;
  logic [1:0]             last_press_clicks;

  // parse step
  logic                   is_esc;
  logic                   is_digit;
  logic                   x10_store;
  logic                   sgr_clear;
  logic                   sgr_digit;
  logic [1:0]             sgr_sel;
  logic [COORD_BITS+3:0]  sgr_acc;
  logic [COORD_BITS-1:0]  sgr_sat;
  logic                   emit_key;
  logic                   emit_mouse;
  logic [7:0]             x10_ctrl;
  logic [COORD_BITS-1:0]  m_ctrl;
  logic [POS_W-1:0]       m_x;
  logic [POS_W-1:0]       m_y;
  logic                   m_x10;
  logic                   m_release;
  logic [BUTTON_BITS-1:0] m_held_next;
  mouse_res_t             m_res;

  // output register
  logic                   out_valid;
  ev_kind_t               out_kind;
  logic [7:0]             out_key;
  logic [POS_W-1:0]       out_x;
  logic [POS_W-1:0]       out_y;
  logic [MASK_W-1:0]      out_mask;
  logic [1:0]             out_clicks;
  logic [TIME_W-1:0]      out_ms;

  // ---------------- configuration port ----------------
  assign pready    = 1'b1;
  assign cfg_index = paddr[CFG_ADDR_W-1];
  assign prdata    = (cfg_index == REG_WINDOW) ? CFG_DATA_W'(window_ms) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms <= WINDOW_RESET;
    end else if (psel && penable && pwrite && cfg_index == REG_WINDOW) begin
      window_ms <= pwdata[WINDOW_W-1:0];
    end
  end

  // ---------------- handshake ----------------
  assign s1_fire           = s1_valid && (!out_valid || event_stream.ready);
  assign byte_stream.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_stream.ready) begin
      s1_valid <= byte_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_stream.ready && byte_stream.valid) begin
      s1_byte <= byte_stream.in_byte;
      s1_ms   <= byte_stream.arrival_ms;
    end
  end

  // ---------------- phase next state ----------------
  assign is_esc   = (s1_byte == CH_ESC);
  assign is_digit = (s1_byte >= CH_ZERO) && (s1_byte <= CH_NINE);

  always_comb begin
    phase_next = phase;
    if (is_esc) begin
      phase_next = PH_ESCAPE;
    end else begin
      unique case (phase)
        PH_GROUND: phase_next = PH_GROUND;
        PH_ESCAPE: begin
          if (s1_byte == CH_LBRACKET) phase_next = PH_CSI;
        end
        PH_CSI: begin
          if (s1_byte == CH_X10) phase_next = PH_X10;
          else if (s1_byte == CH_SGR) phase_next = PH_SGR;
          else phase_next = PH_GROUND;
        end
        PH_X10: begin
          if (x10_count == 2'd2) phase_next = PH_GROUND;
        end
        PH_SGR: begin
          if (!is_digit && s1_byte != CH_SEMI) phase_next = PH_GROUND;
        end
        default: phase_next = PH_GROUND;
      endcase
    end
  end

  // ---------------- parse outputs ----------------
  always_comb begin
    x10_count_next       = x10_count;
    x10_store            = 1'b0;
    sgr_clear            = 1'b0;
    sgr_digit            = 1'b0;
    sgr_field_index_next = sgr_field_index;
    sgr_stopped_next     = sgr_stopped;
    sgr_digit_seen_next  = sgr_digit_seen;
    emit_key             = 1'b0;
    emit_mouse           = 1'b0;
    if (!is_esc) begin
      unique case (phase)
        PH_GROUND: emit_key = 1'b1;
        PH_ESCAPE: ;
        PH_CSI: begin
          if (s1_byte == CH_X10) x10_count_next = 2'd0;
          else if (s1_byte == CH_SGR) begin
            sgr_clear            = 1'b1;
            sgr_field_index_next = 2'd0;
            sgr_stopped_next     = 1'b0;
            sgr_digit_seen_next  = 1'b0;
          end
        end
        PH_X10: begin
          if (x10_count != 2'd2) begin
            x10_store      = 1'b1;
            x10_count_next = x10_count + 2'd1;
          end else begin
            x10_count_next = 2'd0;
            emit_mouse     = 1'b1;
          end
        end
        PH_SGR: begin
          if (is_digit) begin
            if (!sgr_stopped) begin
              sgr_digit           = 1'b1;
              sgr_digit_seen_next = 1'b1;
            end
          end else if (s1_byte == CH_SEMI) begin
            if (!sgr_stopped) begin
              if (!sgr_digit_seen || sgr_field_index >= 2'd2) begin
                sgr_stopped_next = 1'b1;
              end else begin
                sgr_field_index_next = sgr_field_index + 2'd1;
                sgr_digit_seen_next  = 1'b0;
              end
            end
          end else if (s1_byte == CH_X10 || s1_byte == CH_RELEASE) begin
            emit_mouse = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // decimal accumulate with saturation
  assign sgr_sel = (sgr_field_index > 2'd2) ? 2'd2 : sgr_field_index;
  assign sgr_acc = ((COORD_BITS+4)'(sgr_values[sgr_sel]) << 3) +
                   ((COORD_BITS+4)'(sgr_values[sgr_sel]) << 1) +
                   (COORD_BITS+4)'(s1_byte - CH_ZERO);
  assign sgr_sat = (sgr_acc[COORD_BITS+3:COORD_BITS] != 4'd0) ? '1 :
                   sgr_acc[COORD_BITS-1:0];

  // mouse report operands; the X10 control byte wraps at 8 bits
  assign x10_ctrl  = x10_bytes[0] - X10_CTRL_OFFSET;
  assign m_x10     = (phase == PH_X10);
  assign m_release = !m_x10 && (s1_byte == CH_RELEASE);
  assign m_ctrl    = m_x10 ? COORD_BITS'(x10_ctrl) : sgr_values[0];
  assign m_x       = m_x10 ? (POS_W'(x10_bytes[1]) - POS_W'(X10_POS_OFFSET))
                           : ({1'b0, sgr_values[1]} - POS_W'(1));
  assign m_y       = m_x10 ? (POS_W'(s1_byte) - POS_W'(X10_POS_OFFSET))
                           : ({1'b0, sgr_values[2]} - POS_W'(1));

  tmep_mouse #(
    .BUTTON_BITS (BUTTON_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_mouse (
    .ctrl         (m_ctrl),
    .is_x10       (m_x10),
    .is_release   (m_release),
    .held         (held_buttons),
    .last_buttons (last_press_buttons),
    .last_clicks  (last_press_clicks),
    .last_ms      (last_press_ms),
    .now_ms       (s1_ms),
    .window_ms    (window_ms),
    .held_next    (m_held_next),
    .res          (m_res)
  );

  // ---------------- state registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_GROUND;
      x10_count          <= 2'd0;
      sgr_values[0]      <= '0;
      sgr_values[1]      <= '0;
      sgr_values[2]      <= '0;
      sgr_field_index    <= 2'd0;
      sgr_stopped        <= 1'b0;
      sgr_digit_seen     <= 1'b0;
      held_buttons       <= '0;
      last_press_ms      <= '0;
      last_press_buttons <= '0;
      last_press_clicks  <= 2'd0;
    end else if (s1_fire) begin
      phase           <= phase_next;
      x10_count       <= x10_count_next;
      sgr_field_index <= sgr_field_index_next;
      sgr_stopped     <= sgr_stopped_next;
      sgr_digit_seen  <= sgr_digit_seen_next;
      if (sgr_clear) begin
        sgr_values[0] <= '0;
        sgr_values[1] <= '0;
        sgr_values[2] <= '0;
      end else if (sgr_digit) begin
        sgr_values[sgr_sel] <= sgr_sat;
      end
      if (emit_mouse) begin
        held_buttons <= m_held_next;
        if (m_res.record_press) begin
          last_press_ms      <= s1_ms;
          last_press_buttons <= m_held_next;
          last_press_clicks  <= m_res.clicks;
        end
      end
    end
  end

  // X10 payload bytes, written before they are read
  always_ff @(posedge clk) begin
    if (s1_fire && x10_store) begin
      x10_bytes[x10_count[0]] <= s1_byte;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && (emit_key || emit_mouse)) begin
      out_valid <= 1'b1;
    end else if (event_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit_key) begin
      out_kind   <= EV_KEYDOWN;
      out_key    <= s1_byte;
      out_x      <= '0;
      out_y      <= '0;
      out_mask   <= '0;
      out_clicks <= 2'd0;
      out_ms     <= s1_ms;
    end else if (s1_fire && emit_mouse) begin
      out_kind   <= m_res.kind;
      out_key    <= 8'd0;
      out_x      <= m_x;
      out_y      <= m_y;
      out_mask   <= MASK_W'(m_held_next);
      out_clicks <= m_res.clicks;
      out_ms     <= s1_ms;
    end
  end

  assign event_stream.valid       = out_valid;
  assign event_stream.event_kind  = out_kind;
  assign event_stream.key_code    = out_key;
  assign event_stream.pos_x       = out_x;
  assign event_stream.pos_y       = out_y;
  assign event_stream.button_mask = out_mask;
  assign event_stream.click_count = out_clicks;
  assign event_stream.event_ms    = out_ms;

  // ---------------- assertions ----------------
  a_esc_restarts: assert property (@(posedge clk) disable iff (rst)
    s1_fire && is_esc |=> phase == PH_ESCAPE)
    else $error("escape byte did not restart the parser");

  a_stall_holds_byte: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid && $stable(s1_byte) && $stable(s1_ms))
    else $error("input register lost a stalled byte");

  a_event_lands: assert property (@(posedge clk) disable iff (rst)
    s1_fire && (emit_key || emit_mouse) |=> out_valid && out_ms == $past(s1_ms))
    else $error("parsed event did not reach the output register");

  a_x10_count_range: assert property (@(posedge clk) disable iff (rst)
    x10_count != 2'd3)
    else $error("X10 byte count out of range");

endmodule

// ===== test/terminal_mouse_escape_parser_unit_tb.sv =====
// Self-checking testbench of the terminal mouse escape parser unit.
`timescale 1ns / 1ps
module terminal_mouse_escape_parser_unit_tb;
  import tmep_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int LONG_HOLD    = 600;
  localparam int SETTLE       = 8;
  localparam int RANDOM_BYTES = 680;
  localparam int CFG_EVERY    = 350;
  localparam int CB           = COORD_BITS_DEFAULT;

  localparam logic [CFG_ADDR_W-1:0] ADDR_WINDOW = CFG_ADDR_W'(4 * REG_WINDOW);
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE  = CFG_ADDR_W'(4 * (REG_WINDOW + 1));

  // X10 control bytes as sent on the wire (offset by 0x20)
  localparam logic [7:0] X10_LEFT    = 8'h20;
  localparam logic [7:0] X10_RELEASE = 8'h23;
  localparam logic [7:0] X10_MOTION  = 8'h40;
  localparam logic [7:0] X10_WHEEL   = 8'h60;
  localparam logic [7:0] X10_EXT2    = 8'ha0;
  localparam logic [7:0] X10_EXT3    = 8'he0;

  typedef struct packed {
    ev_kind_t          kind;
    logic [7:0]        key;
    logic [CB:0]       pos_x;
    logic [CB:0]       pos_y;
    logic [MASK_W-1:0] mask;
    logic [1:0]        clicks;
    logic [TIME_W-1:0] ms;
  } term_event_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  tmep_byte_if  byte_if ();
  tmep_event_if ev_if ();

  terminal_mouse_escape_parser_unit uut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .byte_stream  (byte_if),
    .event_stream (ev_if)
  );

  // Parser mirror
  phase_t              cur_phase         = PH_GROUND;
  logic [1:0]          x10_got           = '0;
  logic [7:0]          x10_hold [2];
  logic [15:0]         sgr_val [3]       = '{16'd0, 16'd0, 16'd0};
  logic [1:0]          sgr_field         = '0;
  logic                sgr_halted        = 1'b0;
  logic                sgr_has_digit     = 1'b0;
  logic [MASK_W-1:0]   held_mask         = '0;
  logic [TIME_W-1:0]   prev_press_ms     = '0;
  logic [MASK_W-1:0]   prev_press_mask   = '0;
  logic [1:0]          prev_press_clicks = '0;
  logic [WINDOW_W-1:0] window_ms         = WINDOW_RESET;

  term_event_t       expected_events [$];
  logic [TIME_W-1:0] now_ms        = '0;
  int                bytes_sent    = 0;
  int                errors        = 0;
  int                cycles        = 0;
  bit                idle_on       = 1'b1;
  int                long_hold_req = 0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic void mouse_update(input logic [15:0] ctrl, input logic [31:0] x,
                                       input logic [31:0] y, input logic [7:0] cmd,
                                       input logic [31:0] t, output term_event_t ev);
    ev_kind_t    kind;
    logic [1:0]  clicks;
    int unsigned ext;
    int unsigned btn;
    logic [31:0] dt;
    clicks = 2'd0;
    if (ctrl[5]) begin
      kind = EV_MOVE;
    end else begin
      ext = ctrl >> 6;
      btn = ctrl & 16'd3;
      held_mask = held_mask & ~{8'b0, WHEEL_CLEAR};
      if (ext == 0 && btn == 3 && cmd == 8'h00) begin
        held_mask = '0;
        kind = EV_UP;
      end else begin
        if (ext != 0) btn = btn + 4 * ext - 1;
        if (cmd == CH_RELEASE) begin
          if (btn < BUTTON_BITS_DEFAULT) held_mask[btn] = 1'b0;
          kind = EV_UP;
        end else begin
          if (btn < BUTTON_BITS_DEFAULT) held_mask[btn] = 1'b1;
          kind = ((held_mask & {8'b0, WHEEL_MASK}) != 0) ? EV_CLICK : EV_DOWN;
        end
      end
    end
    if (kind == EV_DOWN) begin
      dt = t - prev_press_ms;
      if (dt <= {16'b0, window_ms} && prev_press_mask == held_mask &&
          prev_press_clicks < MAX_CLICKS) begin
        clicks = prev_press_clicks + 2'd1;
        kind = EV_CLICK;
      end
      prev_press_ms = t;
      prev_press_mask = held_mask;
      prev_press_clicks = clicks;
    end else if (kind == EV_CLICK) begin
      clicks = 2'd1;
    end
    ev = '0;
    ev.kind = kind;
    ev.pos_x = x[CB:0];
    ev.pos_y = y[CB:0];
    ev.mask = held_mask;
    ev.clicks = clicks;
    ev.ms = t;
  endfunction

  // Advance the mirror by one byte; returns 1 when the byte completes an event.
  function automatic bit parse_byte(input logic [7:0] ch, input logic [31:0] t,
                                    output term_event_t ev);
    bit          hit;
    logic [31:0] v;
    int unsigned fi;
    hit = 1'b0;
    ev = '0;
    if (ch == CH_ESC) begin
      cur_phase = PH_ESCAPE;
    end else begin
      case (cur_phase)
        PH_GROUND: begin
          ev.kind = EV_KEYDOWN;
          ev.key = ch;
          ev.ms = t;
          hit = 1'b1;
        end
        PH_ESCAPE: begin
          if (ch == CH_LBRACKET) cur_phase = PH_CSI;
        end
        PH_CSI: begin
          if (ch == CH_X10) begin
            cur_phase = PH_X10;
            x10_got = '0;
          end else if (ch == CH_SGR) begin
            cur_phase = PH_SGR;
            sgr_val = '{16'd0, 16'd0, 16'd0};
            sgr_field = '0;
            sgr_halted = 1'b0;
            sgr_has_digit = 1'b0;
          end else begin
            cur_phase = PH_GROUND;
          end
        end
        PH_X10: begin
          if (x10_got < 2) begin
            x10_hold[x10_got[0]] = ch;
            x10_got++;
          end else begin
            cur_phase = PH_GROUND;
            x10_got = '0;
            mouse_update({8'b0, 8'(x10_hold[0] - X10_CTRL_OFFSET)},
                         {24'b0, x10_hold[1]} - {24'b0, X10_POS_OFFSET},
                         {24'b0, ch} - {24'b0, X10_POS_OFFSET}, 8'h00, t, ev);
            hit = 1'b1;
          end
        end
        PH_SGR: begin
          if (ch >= CH_ZERO && ch <= CH_NINE) begin
            if (!sgr_halted) begin
              fi = (sgr_field > 2) ? 2 : sgr_field;
              v = 32'(sgr_val[fi]) * 32'd10 + 32'(ch - CH_ZERO);
              sgr_val[fi] = (v > 32'hffff) ? 16'hffff : v[15:0];
              sgr_has_digit = 1'b1;
            end
          end else if (ch == CH_SEMI) begin
            if (!sgr_halted) begin
              if (!sgr_has_digit || sgr_field >= 2) begin
                sgr_halted = 1'b1;
              end else begin
                sgr_field++;
                sgr_has_digit = 1'b0;
              end
            end
          end else begin
            cur_phase = PH_GROUND;
            if (ch == CH_RELEASE || ch == CH_X10) begin
              mouse_update(sgr_val[0], 32'(sgr_val[1]) - 32'd1, 32'(sgr_val[2]) - 32'd1,
                           ch, t, ev);
              hit = 1'b1;
            end
          end
        end
        default: cur_phase = PH_GROUND;
      endcase
    end
    return hit;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= 100)
      $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycles);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    term_event_t want;
    if (!rst && ev_if.valid && ev_if.ready) begin
      if (expected_events.size() == 0) begin
        report_mismatch("event with none pending", 32'(ev_if.event_kind), 32'd0);
      end else begin
        want = expected_events.pop_front();
        check_field("event_kind", 32'(ev_if.event_kind), 32'(want.kind));
        check_field("key_code", 32'(ev_if.key_code), 32'(want.key));
        check_field("pos_x", {15'b0, ev_if.pos_x}, {15'b0, want.pos_x});
        check_field("pos_y", {15'b0, ev_if.pos_y}, {15'b0, want.pos_y});
        check_field("button_mask", 32'(ev_if.button_mask), 32'(want.mask));
        check_field("click_count", 32'(ev_if.click_count), 32'(want.clicks));
        check_field("event_ms", ev_if.event_ms, want.ms);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_dt();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 5);
    if (r < 88) return $urandom_range(0, 600);
    if (r < 98) return $urandom_range(0, 70000);
    return $urandom();
  endfunction

  // Event sink: random stalls, plus a long hold-off on request.
  initial begin
    int stall_left;
    int long_hold_done;
    stall_left = 0;
    long_hold_done = 0;
    ev_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) stall_left--;
      else if (long_hold_req != long_hold_done) begin
        stall_left = LONG_HOLD;
        long_hold_done++;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        stall_left = pick_gap();
      end
      ev_if.ready <= (stall_left == 0);
    end
  end

  // Called at a falling edge; returns at a falling edge with valid still high
  // unless a gap was taken.
  task automatic send_byte(input logic [7:0] b, input logic [31:0] dt);
    term_event_t ev;
    int          gap;
    now_ms = now_ms + dt;
    byte_if.valid <= 1'b1;
    byte_if.in_byte <= b;
    byte_if.arrival_ms <= now_ms;
    do @(posedge clk); while (!byte_if.ready);
    if (parse_byte(b, now_ms, ev)) expected_events.push_back(ev);
    bytes_sent++;
    @(negedge clk);
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // The last byte carries the time step: in a full report it completes the event.
  task automatic send_text(input string s, input logic [31:0] dt);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], (i == s.len() - 1) ? dt : 32'd0);
  endtask

  task automatic send_x10(input logic [7:0] c, input logic [7:0] x, input logic [7:0] y,
                          input logic [31:0] dt);
    send_text("\033[M", 32'd0);
    send_byte(c, 32'd0);
    send_byte(x, 32'd0);
    send_byte(y, dt);
  endtask

  task automatic drain_events();
    byte_if.valid <= 1'b0;
    while (expected_events.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_WINDOW) window_ms = data[WINDOW_W-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic test_key_bytes();
    send_byte(8'h00, 32'd1);
    send_byte(8'hff, 32'd1);
    send_byte("a", 32'd0);
    // escape swallows bytes until '[', an unknown final drops back to ground
    send_text("\033z[A", 32'd2);
    send_byte("q", 32'd1);
    // escape restarts a half-received report
    send_text("\033[M ", 32'd0);
    send_text("\033\033[M !!", 32'd3);
  endtask

  task automatic test_x10_reports();
    send_x10(8'h00, 8'h00, 8'hff, 32'd1);
    send_x10(8'h1f, 8'hff, 8'h00, 32'd1);
    send_x10(X10_EXT2, 8'h40, 8'h41, 32'd1);
    send_x10(X10_EXT3 | 8'h02, 8'h42, 8'h43, 32'd1);
    send_x10(X10_WHEEL, 8'h44, 8'h45, 32'd1);
    send_x10(X10_MOTION, 8'h46, 8'h47, 32'd1);
    send_x10(X10_RELEASE, 8'h48, 8'h49, 32'd1);
    // repeated clicks climb to three, then fall back to a plain press
    repeat (5) begin
      send_x10(X10_LEFT, 8'h30, 8'h30, 32'd10);
      send_x10(X10_RELEASE, 8'h30, 8'h30, 32'd5);
    end
  endtask

  task automatic test_sgr_reports();
    send_text("\033[<0;10;20M", 32'd1);
    send_text("\033[<0;10;20m", 32'd1);
    send_text("\033[<;;M", 32'd1);
    send_text("\033[<0;99999999;5M", 32'd1);
    send_text("\033[<1;1;2;3M", 32'd1);
    send_text("\033[<320;7;7M", 32'd1);
    send_text("\033[<65535;3;4M", 32'd1);
    send_text("\033[<3;5;5M", 32'd1);
    send_text("\033[<1;2x", 32'd1);
    send_text("\033[<1;2;3m", 32'd1);
  endtask

  task automatic test_click_window();
    logic [15:0] w;
    for (int k = 0; k < 5; k++) begin
      case (k)
        0: w = 16'd0;
        1: w = 16'hffff;
        2: w = 16'd1;
        3: w = 16'($urandom());
        default: w = WINDOW_RESET;
      endcase
      drain_events();
      write_reg(ADDR_WINDOW, {16'($urandom()), w});
      send_x10(X10_LEFT, 8'h30, 8'h31, 32'd1);
      send_x10(X10_RELEASE, 8'h30, 8'h31, 32'd0);
      send_x10(X10_LEFT, 8'h30, 8'h31, 32'(w));
      send_x10(X10_RELEASE, 8'h30, 8'h31, 32'd0);
      send_x10(X10_LEFT, 8'h30, 8'h31, 32'(w) + 32'd1);
    end
    drain_events();
    write_reg(ADDR_SPARE, $urandom());
  endtask

  task automatic test_backpressure();
    byte_if.valid <= 1'b0;
    idle_on = 1'b0;
    @(posedge clk);
    long_hold_req++;
    @(negedge clk);
    for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(32, 126)), 32'd1);
    drain_events();
    idle_on = 1'b1;
  endtask

  function automatic string sgr_number();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return "";
    if (r < 10) return $sformatf("%0d", $urandom_range(0, 99999999));
    if (r < 14) return $sformatf("00%0d", $urandom_range(0, 9));
    return $sformatf("%0d", $urandom_range(1, 300));
  endfunction

  function automatic string sgr_button();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $sformatf("%0d", $urandom_range(0, 2));
    if (r < 50) return "3";
    if (r < 62) return $sformatf("%0d", 64 + $urandom_range(0, 3));
    if (r < 72) return $sformatf("%0d", 32 + $urandom_range(0, 3));
    if (r < 80) return $sformatf("%0d", $urandom_range(0, 31));
    if (r < 90) return $sformatf("%0d", $urandom_range(0, 400));
    if (r < 95) return $sformatf("%0d", $urandom_range(0, 65535));
    return "";
  endfunction

  task automatic random_sgr();
    string      s;
    int         r;
    logic [7:0] last;
    s = {"\033[<", sgr_button(), ";", sgr_number(), ";", sgr_number()};
    r = $urandom_range(0, 99);
    if (r < 5) s = {s, ";", sgr_number()};
    else if (r < 8) s = {s, ";;"};
    send_text(s, 32'd0);
    r = $urandom_range(0, 99);
    if (r < 45) last = CH_X10;
    else if (r < 90) last = CH_RELEASE;
    else last = 8'($urandom_range(0, 255));
    send_byte(last, pick_dt());
  endtask

  task automatic random_x10();
    int         r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 25) c = X10_LEFT + 8'($urandom_range(0, 2));
    else if (r < 45) c = X10_RELEASE;
    else if (r < 55) c = X10_WHEEL + 8'($urandom_range(0, 1));
    else if (r < 65) c = X10_MOTION + 8'($urandom_range(0, 3));
    else if (r < 72) c = X10_EXT2 + 8'($urandom_range(0, 3));
    else if (r < 78) c = X10_EXT3 + 8'($urandom_range(0, 3));
    else c = 8'($urandom());
    // modifier bits ride along with the button code
    if ($urandom_range(0, 4) == 0) c = c | 8'($urandom_range(0, 7) << 2);
    if ($urandom_range(0, 19) == 0) begin
      send_text("\033[M", 32'd0);
      send_byte(c, 32'd0);
    end else begin
      send_x10(c, 8'($urandom()), 8'($urandom()), pick_dt());
    end
  endtask

  task automatic random_noise(input bit plain);
    int         n;
    int         r;
    logic [7:0] b;
    n = $urandom_range(1, 6);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (plain || r < 40) b = 8'($urandom());
      else if (r < 55) b = CH_ESC;
      else if (r < 65) b = CH_LBRACKET;
      else if (r < 72) b = CH_X10;
      else if (r < 79) b = CH_SGR;
      else if (r < 86) b = CH_SEMI;
      else if (r < 94) b = CH_ZERO + 8'($urandom_range(0, 9));
      else b = CH_RELEASE;
      send_byte(b, pick_dt());
    end
  endtask

  task automatic test_random_traffic();
    int          r;
    int          stop_at;
    int          next_cfg;
    logic [15:0] w;
    stop_at = bytes_sent + RANDOM_BYTES;
    next_cfg = bytes_sent + CFG_EVERY;
    while (bytes_sent < stop_at) begin
      idle_on = ((bytes_sent / 250) % 3) != 2;
      if (bytes_sent >= next_cfg) begin
        next_cfg = bytes_sent + CFG_EVERY;
        r = $urandom_range(0, 99);
        if (r < 30) w = 16'($urandom_range(0, 20));
        else if (r < 60) w = 16'($urandom_range(200, 600));
        else if (r < 80) w = 16'hffff;
        else w = 16'($urandom());
        drain_events();
        write_reg(ADDR_WINDOW, {16'($urandom()), w});
      end
      r = $urandom_range(0, 99);
      if (r < 35) random_x10();
      else if (r < 70) random_sgr();
      else if (r < 88) random_noise(1'b1);
      else random_noise(1'b0);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    byte_if.valid = 1'b0;
    byte_if.in_byte = '0;
    byte_if.arrival_ms = '0;
    now_ms = 32'hffff_ff00;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_key_bytes();
    test_x10_reports();
    test_sgr_reports();
    test_click_window();
    test_backpressure();
    test_random_traffic();
    drain_events();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== terminal_mouse_escape_parser_unit.f =====
src/tmep_pkg.sv
src/tmep_byte_if.sv
src/tmep_event_if.sv
src/tmep_mouse.sv
src/terminal_mouse_escape_parser_unit.sv
test/terminal_mouse_escape_parser_unit_tb.sv
